/* rtl/sgl_pkg.sv */
// Shared types, constants and elaboration-time table builders for the sRGB to gray block.
package sgl_pkg;

   localparam int ChanW      = 8;
   localparam int LinW       = 16;
   localparam int SumW       = 32;
   localparam int GrayW      = 8;
   localparam int LinStages  = 3;
   localparam int GammaStages = GrayW;
   localparam int RomDepth   = 256;
   localparam int BigW       = 256;

   localparam logic [LinW-1:0] WeightRed   = 16'd13933;
   localparam logic [LinW-1:0] WeightGreen = 16'd46871;
   localparam logic [LinW-1:0] WeightBlue  = 16'd4732;

   typedef logic [BigW-1:0]        big_type;
   typedef logic [LinW-1:0]        lin_type;
   typedef logic [LinStages-1:0]   lin_en_type;
   typedef logic [GammaStages-1:0] gamma_en_type;

   function automatic big_type big_pow(input big_type base, input int unsigned n);
      big_type acc;
      acc = big_type'(1);
      for (int unsigned t = 0; t < n; t++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

   // round(65535*lin(v/255)) >= k, exact, for v past the linear segment
   function automatic logic lin_at_least(input int unsigned v, input int unsigned k);
      big_type lhs;
      big_type rhs;
      lhs = big_pow(big_type'(10761), 12) * big_pow(big_type'(2 * k - 1), 5);
      rhs = big_pow(big_type'(40 * v + 561), 12) * big_pow(big_type'(131070), 5);
      return lhs <= rhs;
   endfunction

   function automatic lin_type lin_entry(input int unsigned v);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (v * 100000 <= 1031475) begin
         return LinW'((1310700 * v + 32946) / 65892);
      end
      lo = 1;
      hi = 65535;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (lin_at_least(v, mid)) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return LinW'(lo);
   endfunction

   // floor(255*cmp(i/2^lb)) >= g, exact
   function automatic logic gray_at_least(input int unsigned i, input int unsigned g,
                                          input int unsigned lb);
      longint unsigned scale;
      big_type lhs;
      big_type rhs;
      scale = longint'(1) << lb;
      if (longint'(i) * 10000000 <= 31308 * scale) begin
         return 32946 * longint'(i) >= 10 * longint'(g) * scale;
      end
      lhs = big_pow(big_type'(10761), 12) * big_pow(big_type'(i), 5);
      rhs = big_pow(big_type'(40 * g + 561), 12) << (5 * lb);
      return lhs >= rhs;
   endfunction

   // smallest linear index that reaches gray level g
   function automatic int unsigned gray_thr(input int unsigned g, input int unsigned lb);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (g == 0) begin
         return 0;
      end
      lo = 0;
      hi = 1 << lb;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (gray_at_least(mid, g, lb)) begin
            hi = mid;
         end else begin
            lo = mid + 1;
         end
      end
      return lo;
   endfunction

endpackage

/* rtl/sgl_linear.sv */
// Linearizing ROM lookup, luminance weighting and sum: three pipeline stages.
module sgl_linear #(
   parameter int LINEAR_BITS = 12
) (
   input  logic                          clock,
   input  sgl_pkg::lin_en_type           en,
   input  logic [sgl_pkg::ChanW-1:0]     red,
   input  logic [sgl_pkg::ChanW-1:0]     green,
   input  logic [sgl_pkg::ChanW-1:0]     blue,
   output logic [LINEAR_BITS-1:0]        idx
);

   sgl_pkg::lin_type lin_rom [sgl_pkg::RomDepth];

   for (genvar v = 0; v < sgl_pkg::RomDepth; v++) begin : g_rom
      localparam sgl_pkg::lin_type Entry = sgl_pkg::lin_entry(v);
      assign lin_rom[v] = Entry;
   end

   sgl_pkg::lin_type              lin_r_ff, lin_g_ff, lin_b_ff;
   logic [sgl_pkg::SumW-1:0]      prod_r_ff, prod_g_ff, prod_b_ff;
   logic [sgl_pkg::SumW-1:0]      sum_in;
   logic [LINEAR_BITS-1:0]        idx_ff;

   assign sum_in = prod_r_ff + prod_g_ff + prod_b_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lin_r_ff <= lin_rom[red];
         lin_g_ff <= lin_rom[green];
         lin_b_ff <= lin_rom[blue];
      end
      if (en[1]) begin
         prod_r_ff <= lin_r_ff * sgl_pkg::WeightRed;
         prod_g_ff <= lin_g_ff * sgl_pkg::WeightGreen;
         prod_b_ff <= lin_b_ff * sgl_pkg::WeightBlue;
      end
      if (en[2]) begin
         idx_ff <= sum_in[sgl_pkg::SumW-1 -: LINEAR_BITS];
      end
   end

   assign idx = idx_ff;

endmodule

/* rtl/sgl_gamma.sv */
// Gamma compression: pipelined binary search of the gray-level thresholds, one bit per stage.
module sgl_gamma #(
   parameter int LINEAR_BITS = 12
) (
   input  logic                          clock,
   input  sgl_pkg::gamma_en_type         en,
   input  logic [LINEAR_BITS-1:0]        idx,
   output logic [sgl_pkg::GrayW-1:0]     gray
);

   localparam int ThrW = LINEAR_BITS + 1;
   localparam int Steps = sgl_pkg::GammaStages;

   logic [ThrW-1:0] thr [sgl_pkg::RomDepth];

   for (genvar g = 0; g < sgl_pkg::RomDepth; g++) begin : g_thr
      localparam logic [ThrW-1:0] Thr = ThrW'(sgl_pkg::gray_thr(g, LINEAR_BITS));
      assign thr[g] = Thr;
   end

   logic [LINEAR_BITS-1:0]     idx_ff [Steps-1];
   logic [sgl_pkg::GrayW-1:0]  g_ff   [Steps];

   for (genvar j = 0; j < Steps; j++) begin : g_step
      localparam logic [sgl_pkg::GrayW-1:0] Bit = sgl_pkg::GrayW'(1 << (Steps - 1 - j));
      logic [LINEAR_BITS-1:0]    idx_prev;
      logic [sgl_pkg::GrayW-1:0] g_prev;
      logic [sgl_pkg::GrayW-1:0] probe;
      logic [sgl_pkg::GrayW-1:0] g_in;

      if (j == 0) begin : g_first
         assign idx_prev = idx;
         assign g_prev   = '0;
      end else begin : g_next
         assign idx_prev = idx_ff[j-1];
         assign g_prev   = g_ff[j-1];
      end

      assign probe = g_prev | Bit;
      assign g_in  = (thr[probe] <= {1'b0, idx_prev}) ? probe : g_prev;

      always_ff @(posedge clock) begin
         if (en[j]) begin
            g_ff[j] <= g_in;
         end
      end

      if (j < Steps - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[j]) begin
               idx_ff[j] <= idx_prev;
            end
         end
      end
   end

   assign gray = g_ff[Steps-1];

endmodule

/* rtl/srgb_to_gray_luma.sv */
// Top level: sRGB pixel to Rec.709 gray level, fully pipelined.
//
// Input beats arrive on req_valid/req_ready carrying req_red, req_green and
// req_blue (sRGB bytes); each gives exactly one beat on rsp_valid/rsp_ready
// carrying rsp_gray, in order.
// Pipeline: 3 stages of linearizing ROM, 16x16 weighting and sum, then 8
// stages of threshold search, one gray bit per stage: 11 register stages.
// Throughput: one pixel per clock while the output is not held, set by the 11-stage
// pipeline with a valid bit per stage.
// Stall: each stage holds while it is full and the stage after it holds, so
// empty stages still fill and req_ready stays high while any stage is free.
// Nothing is lost or repeated across a stall.
// Reset (synchronous, active high) clears all valid bits; no result is
// pending afterwards. Tables are constants, no initialization pass.
module srgb_to_gray_luma #(
   parameter int LINEAR_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sgl_pkg::ChanW-1:0]   req_red,
   input  logic [sgl_pkg::ChanW-1:0]   req_green,
   input  logic [sgl_pkg::ChanW-1:0]   req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sgl_pkg::GrayW-1:0]   rsp_gray
);

   localparam int Stages = sgl_pkg::LinStages + sgl_pkg::GammaStages;

   logic [Stages-1:0]      valid_ff, valid_in, valid_shift, en;
   logic [LINEAR_BITS-1:0] idx;

   // stage k loads when it and every stage after it are not all full, or output drains
   for (genvar k = 0; k < Stages; k++) begin : g_en
      assign en[k] = rsp_ready || !(&valid_ff[Stages-1:k]);
   end

   assign valid_shift = {valid_ff[Stages-2:0], req_valid};
   assign valid_in    = (valid_shift & en) | (valid_ff & ~en);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   sgl_linear #(
      .LINEAR_BITS(LINEAR_BITS)
   ) u_linear (
      .clock (clock),
      .en    (en[sgl_pkg::LinStages-1:0]),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .idx   (idx)
   );

   sgl_gamma #(
      .LINEAR_BITS(LINEAR_BITS)
   ) u_gamma (
      .clock (clock),
      .en    (en[Stages-1:sgl_pkg::LinStages]),
      .idx   (idx),
      .gray  (rsp_gray)
   );

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[Stages-1];

   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> req_ready)
      else $error("pipeline has a free stage but refuses input");

   a_drain_accepts: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("output drains but input is stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

endmodule
